>>> sv/fpht_pkg.sv
// ----------------------------------------------------------------------------
// fpht_pkg
// Shared widths, register codes, reset values and the per-bar state word of
// the falling peak-hold tracker.
// ----------------------------------------------------------------------------
package fpht_pkg;

  localparam int IDX_W      = 5;
  localparam int RAW_W      = 20;
  localparam int LVL_W      = 17;
  localparam int SPD_W      = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 40;

  localparam logic [LVL_W-1:0] LEVEL_ONE = 17'd65536;

  localparam logic [15:0] RST_FALL_RATE        = 16'd1638;
  localparam logic [18:0] RST_FALL_ACCEL       = 19'd22938;
  localparam logic [20:0] RST_MAX_FALL_SPEED   = 21'd589824;
  localparam logic [3:0]  RST_FORCE_GAIN       = 4'd6;
  localparam logic [15:0] RST_ELASTIC_COEFF    = 16'd39322;
  localparam logic [15:0] RST_MIN_ELASTIC_STEP = 16'd1311;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FALL_RATE        = 3'd0,
    REG_FALL_ACCEL       = 3'd1,
    REG_MAX_FALL_SPEED   = 3'd2,
    REG_FORCE_GAIN       = 3'd3,
    REG_ELASTIC_COEFF    = 3'd4,
    REG_MIN_ELASTIC_STEP = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SPD_W-1:0] spd;
    logic        [LVL_W-1:0] peak;
  } bar_state_t;

endpackage

>>> sv/falling_peak_hold_tracker_top.sv
// ----------------------------------------------------------------------------
// falling_peak_hold_tracker_top
// Peak-hold marker with falling physics for a stream of spectrum bars; peak
// and fall speed per bar live in one synchronous state memory.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless a bar hazard or a stalled output holds it,
// and presents one result beat per input beat through the stage-1 register
// (state read, clamp and multiply), the stage-2 register (update/write-back)
// and the output register. The per-bar read-modify-write loop through the
// state memory sets the rate: a beat whose bar matches the beat accepted just
// before it waits while that beat is in stage 1, longer while results are
// stalled, until that update is written, then reads it via a write-to-read
// bypass. After reset every bar reads as zero peak and zero speed at once
// through per-entry valid bits; there is no clearing pass. Configuration
// writes are taken in any cycle; issue them only while no beat is in flight.
module falling_peak_hold_tracker_top #(
  parameter int NUM_BARS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // bar_index[4:0], raw_level[24:5], zero pad
  input  logic [fpht_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_index[4:0], bar_level[21:5], peak_level[38:22], zero pad
  output logic [fpht_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fpht_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fpht_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fpht_pkg::*;

  localparam int MAX_BARS = 1 << IDX_W;
  localparam int DEPTH    = (NUM_BARS < MAX_BARS) ? NUM_BARS : MAX_BARS;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PAD_W    = M_TDATA_W - IDX_W - 2 * LVL_W;

  localparam logic signed [23:0] SPD_HI = 24'sd2097151;
  localparam logic signed [23:0] SPD_LO = -24'sd2097152;

  function automatic logic signed [SPD_W-1:0] sat_spd(input logic signed [23:0] v);
    logic signed [23:0] r;
    if (v > SPD_HI) begin
      r = SPD_HI;
    end else if (v < SPD_LO) begin
      r = SPD_LO;
    end else begin
      r = v;
    end
    return r[SPD_W-1:0];
  endfunction

  // configuration registers
  logic [15:0] fall_rate_q;
  logic [18:0] fall_accel_q;
  logic [20:0] max_speed_q;
  logic [3:0]  gain_q;
  logic [15:0] elastic_q;
  logic [15:0] min_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_rate_q  <= RST_FALL_RATE;
      fall_accel_q <= RST_FALL_ACCEL;
      max_speed_q  <= RST_MAX_FALL_SPEED;
      gain_q       <= RST_FORCE_GAIN;
      elastic_q    <= RST_ELASTIC_COEFF;
      min_step_q   <= RST_MIN_ELASTIC_STEP;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FALL_RATE:        fall_rate_q  <= cfg_data_i[15:0];
        REG_FALL_ACCEL:       fall_accel_q <= cfg_data_i[18:0];
        REG_MAX_FALL_SPEED:   max_speed_q  <= cfg_data_i[20:0];
        REG_FORCE_GAIN:       gain_q       <= cfg_data_i[3:0];
        REG_ELASTIC_COEFF:    elastic_q    <= cfg_data_i[15:0];
        REG_MIN_ELASTIC_STEP: min_step_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // input beat
  logic [IDX_W-1:0]        in_idx;
  logic signed [RAW_W-1:0] in_raw;
  logic [AW-1:0]           in_addr;
  logic                    in_inr;

  assign in_idx  = s_axis_tdata[IDX_W-1:0];
  assign in_raw  = $signed(s_axis_tdata[IDX_W+RAW_W-1:IDX_W]);
  assign in_addr = AW'(in_idx);
  assign in_inr  = (32'(in_idx) < NUM_BARS);

  // pipeline control
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_inr_q, s2_inr_q;
  logic [AW-1:0] s1_addr_q, s2_addr_q;
  logic out_en, s2_en, s1_en, wr_en, hazard, accept;

  assign out_en = !out_valid_q || m_axis_tready;
  assign s2_en  = !s2_valid_q || out_en;
  assign s1_en  = !s1_valid_q || s2_en;
  assign wr_en  = s2_valid_q && out_en && s2_inr_q;

  // hold a beat whose bar is still being updated ahead of it
  assign hazard = in_inr &&
                  ((s1_valid_q && s1_inr_q && (s1_addr_q == in_addr)) ||
                   (s2_valid_q && s2_inr_q && (s2_addr_q == in_addr) && !out_en));

  assign s_axis_tready = s1_en && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // state memory
  bar_state_t       mem [DEPTH];
  bar_state_t       mem_rd_q;
  bar_state_t       byp_state_q;
  bar_state_t       wr_state;
  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q, byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s2_addr_q] <= wr_state;
    end
    if (accept) begin
      mem_rd_q    <= mem[in_addr];
      byp_state_q <= wr_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[s2_addr_q] <= 1'b1;
      end
      if (accept) begin
        rd_vld_q <= vld_q[in_addr];
        byp_q    <= wr_en && (s2_addr_q == in_addr);
      end
    end
  end

  // stage 1: clamp and multiply
  logic [IDX_W-1:0]        s1_idx_q;
  logic signed [RAW_W-1:0] s1_raw_q;
  bar_state_t              cur;
  logic [LVL_W-1:0]        s1_bar;
  logic signed [38:0]      prod_d, prod_e;
  logic signed [17:0]      pb;
  logic signed [22:0]      pbg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q  <= in_idx;
      s1_addr_q <= in_addr;
      s1_raw_q  <= in_raw;
      s1_inr_q  <= in_inr;
    end
  end

  always_comb begin
    if (byp_q) begin
      cur = byp_state_q;
    end else if (rd_vld_q) begin
      cur = mem_rd_q;
    end else begin
      cur = '0;
    end
    if (s1_raw_q[RAW_W-1]) begin
      s1_bar = '0;
    end else if (s1_raw_q > $signed({3'b000, LEVEL_ONE})) begin
      s1_bar = LEVEL_ONE;
    end else begin
      s1_bar = s1_raw_q[LVL_W-1:0];
    end
    prod_d = $signed({1'b0, fall_rate_q}) * cur.spd;
    prod_e = $signed({1'b0, elastic_q}) * cur.spd;
    pb     = $signed({1'b0, cur.peak}) - $signed({1'b0, s1_bar});
    pbg    = pb * $signed({1'b0, gain_q});
  end

  // stage 2: bounce or fall, then write back
  logic [IDX_W-1:0]        s2_idx_q;
  logic [LVL_W-1:0]        s2_bar_q, s2_peak_q;
  logic signed [SPD_W-1:0] s2_spd_q;
  logic signed [22:0]      s2_d_q, s2_e_q, s2_pbg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      s2_idx_q  <= s1_idx_q;
      s2_addr_q <= s1_addr_q;
      s2_inr_q  <= s1_inr_q;
      s2_bar_q  <= s1_bar;
      s2_peak_q <= cur.peak;
      s2_spd_q  <= cur.spd;
      s2_d_q    <= prod_d[38:16];
      s2_e_q    <= prod_e[38:16];
      s2_pbg_q  <= pbg;
    end
  end

  logic signed [23:0] pmd, bar24, spd_b, sum_f, max24, spd_f;
  logic signed [22:0] e_use;
  logic [LVL_W-1:0]   peak_f, new_peak;
  logic               bounce;

  always_comb begin
    pmd    = $signed({7'b0, s2_peak_q}) - $signed({s2_d_q[22], s2_d_q});
    bar24  = $signed({7'b0, s2_bar_q});
    bounce = (pmd <= bar24);
    e_use  = (s2_d_q > $signed({7'b0, min_step_q})) ? s2_e_q : '0;
    spd_b  = $signed({s2_pbg_q[22], s2_pbg_q}) - $signed({e_use[22], e_use});
    sum_f  = $signed({{2{s2_spd_q[SPD_W-1]}}, s2_spd_q}) + $signed({5'b0, fall_accel_q});
    max24  = $signed({3'b0, max_speed_q});
    spd_f  = (sum_f <= max24) ? sum_f : max24;
    if (pmd > 24'sd0) begin
      if (pmd > $signed({7'b0, LEVEL_ONE})) begin
        peak_f = LEVEL_ONE;
      end else begin
        peak_f = pmd[LVL_W-1:0];
      end
    end else begin
      peak_f = '0;
    end
    new_peak      = bounce ? s2_bar_q : peak_f;
    wr_state.peak = new_peak;
    wr_state.spd  = sat_spd(bounce ? spd_b : spd_f);
  end

  // output register
  logic [IDX_W-1:0] out_idx_q;
  logic [LVL_W-1:0] out_bar_q, out_peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2_valid_q) begin
      out_idx_q  <= s2_idx_q;
      out_bar_q  <= s2_bar_q;
      out_peak_q <= s2_inr_q ? new_peak : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_peak_q, out_bar_q, out_idx_q};

`ifndef ASSERT_OFF
  a_no_bar_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && s1_inr_q && s2_inr_q) |-> (s1_addr_q != s2_addr_q))
    else $error("two updates of one bar in flight");

  a_levels_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((out_peak_q <= LEVEL_ONE) && (out_bar_q <= LEVEL_ONE)))
    else $error("result level above full scale");

  a_write_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> out_valid_q)
    else $error("state written without a result beat");
`endif

endmodule
